// File: src/ssaw_pkg.sv
package ssaw_pkg;

	// default sizes
	localparam int ACK_WINDOW_DEF    = 2048;
	localparam int QUEUE_DEPTH_DEF   = 16;
	localparam int MAX_SEGMENT_BYTES = 4096;
	localparam int MAX_RESULTS       = 16;
	localparam int NW                = $clog2(MAX_RESULTS + 1);

	// register reset values
	localparam logic [12:0] SEG_BYTES_RST = 13'd4096;
	localparam logic [11:0] LIMIT_RST     = 12'd512;

	// register indexes
	localparam logic REG_SEG_BYTES = 1'b0;
	localparam logic REG_LIMIT     = 1'b1;

	// command codes
	localparam logic [1:0] CMD_PUSH = 2'd0;
	localparam logic [1:0] CMD_NEXT = 2'd1;
	localparam logic [1:0] CMD_ACK  = 2'd2;

	// status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_STALE    = 3'd1;
	localparam logic [2:0] ST_FUTURE   = 3'd2;
	localparam logic [2:0] ST_WINDOW   = 3'd3;
	localparam logic [2:0] ST_EMPTY    = 3'd4;
	localparam logic [2:0] ST_LIMIT    = 3'd5;
	localparam logic [2:0] ST_FULL     = 3'd6;
	localparam logic [2:0] ST_COMPLETE = 3'd7;

	typedef struct packed {
		logic [15:0] id;
		logic [31:0] left;
		logic        rd;
		logic [31:0] msg;
		logic [31:0] start;
		logic [31:0] count;
	} req_entry_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] msg_seq;
		logic [31:0] seg_seq;
		logic [31:0] seg_count;
		logic [12:0] seg_len;
		logic [12:0] payload_len;
		logic [12:0] carrier_len;
		logic [15:0] out_id;
	} result_t;

	// bitmap port controls
	typedef struct packed {
		logic re;
		logic we;
		logic wbit;
	} bm_ctl_t;

	// segment size clamped to the usable range
	function automatic logic [12:0] seg_eff(input logic [12:0] raw);
		logic [12:0] r;
		r = raw;
		if (raw == 13'd0) r = 13'd1;
		else if (raw > 13'(MAX_SEGMENT_BYTES)) r = 13'(MAX_SEGMENT_BYTES);
		return r;
	endfunction

endpackage

// File: src/segment_sequencer_ack_window.sv
// channel   | direction | handshake             | word
// command   | in        | start, busy           | cmd, request_id, request_bytes, is_read, ack_seq
// result    | out       | strobe (one cycle)    | status .. out_id, last
// config    | in/out    | psel, penable, pready | paddr, pwdata, prdata
//
// push: busy while the one-bit-a-cycle divider runs; a refused push or next passes S_SPR and S_FIN.
// next: the table scan steps past each queued request with nothing left to send, then S_FIN.
// ack: a refused ack goes from S_MARK to S_FIN, else the acknowledged bits are walked in the
// bitmap; when the oldest pointer moves, S_ADV and a walk over each queued request follow,
// completions leaving as it walks. after reset a clearing pass over all ACK_WINDOW bitmap bits
// runs with busy high. results cannot be held off: each strobe lasts exactly one cycle.
module segment_sequencer_ack_window import ssaw_pkg::*; #(
	parameter int ACK_WINDOW  = ACK_WINDOW_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [15:0] request_id,
	input  logic [31:0] request_bytes,
	input  logic        is_read,
	input  logic [31:0] ack_seq,
	output logic        strobe,
	output logic [2:0]  status,
	output logic [31:0] msg_seq,
	output logic [31:0] seg_seq,
	output logic [31:0] seg_count,
	output logic [12:0] seg_len,
	output logic [12:0] payload_len,
	output logic [12:0] carrier_len,
	output logic [15:0] out_id,
	output logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW = $clog2(ACK_WINDOW);
	localparam int KW = $clog2(ACK_WINDOW + 1);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int IW = $clog2(QUEUE_DEPTH);

	typedef enum logic [10:0] {
		S_CLR  = 11'b00000000001,
		S_IDLE = 11'b00000000010,
		S_DIV  = 11'b00000000100,
		S_NSCN = 11'b00000001000,
		S_MARK = 11'b00000010000,
		S_RD   = 11'b00000100000,
		S_CHK  = 11'b00001000000,
		S_ADV  = 11'b00010000000,
		S_CMPL = 11'b00100000000,
		S_FIN  = 11'b01000000000,
		S_SPR  = 11'b10000000000
	} state_t;

	state_t      state_q;
	logic [12:0] seg_bytes_q;
	logic [11:0] limit_q;
	logic [31:0] oldest_q, next_q, msgc_q, alloc_q;
	logic [AW-1:0] ptr_q, baddr_q, clr_q;
	logic [CW-1:0] cnt_q, idx_q, j_q;
	logic [KW-1:0] k_q;
	logic [NW-1:0] ncmp_q;
	logic [1:0]  cmd_q;
	logic [15:0] id_q;
	logic [31:0] bytes_q, ack_q;
	logic        rd_q;
	result_t     hold_q, out_q;
	logic        hold_v_q, strobe_q, last_q;
	req_entry_t  tbl_q [QUEUE_DEPTH];

	logic [31:0] inflight, d_ack, past, cnt_v;
	logic [12:0] ss, len;
	logic [AW:0] msum;
	logic [AW-1:0] mark_addr, baddr_nx, bm_addr;
	req_entry_t  e, tbl_wd;
	logic        tbl_we, done_e, accept;
	logic [IW-1:0] tbl_wa;
	result_t     emit_res;
	logic        emit_v;
	bm_ctl_t     bm_ctl;
	logic        bm_rbit, div_done, div_rem_nz, div_start;
	logic [31:0] div_q;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && (state_q == S_IDLE);
	assign pready = 1'b1;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_bytes_q <= SEG_BYTES_RST;
			limit_q     <= LIMIT_RST;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_SEG_BYTES) seg_bytes_q <= pwdata[12:0];
			else limit_q <= pwdata[11:0];
		end
	end

	assign prdata = (paddr[2] == REG_LIMIT) ? {20'd0, limit_q} : {19'd0, seg_bytes_q};

	// shared helpers
	always_comb begin
		e         = tbl_q[idx_q[IW-1:0]];
		ss        = seg_eff(seg_bytes_q);
		inflight  = next_q - oldest_q;
		d_ack     = ack_q - oldest_q;
		past      = oldest_q - e.start;
		done_e    = !past[31] && (past >= e.count);
		cnt_v     = div_q + {31'd0, div_rem_nz};
		len       = (e.left > {19'd0, ss}) ? ss : e.left[12:0];
		msum      = {1'b0, ptr_q} + {1'b0, d_ack[AW-1:0]};
		mark_addr = (msum >= (AW+1)'(ACK_WINDOW)) ?
			AW'(msum - (AW+1)'(ACK_WINDOW)) : msum[AW-1:0];
		baddr_nx  = (baddr_q == AW'(ACK_WINDOW - 1)) ? '0 : baddr_q + 1'b1;
		div_start = accept && (cmd == CMD_PUSH) && (cnt_q != CW'(QUEUE_DEPTH));
	end

	// result production and table write port
	always_comb begin
		emit_v   = 1'b0;
		emit_res = '0;
		tbl_we   = 1'b0;
		tbl_wa   = idx_q[IW-1:0];
		tbl_wd   = e;
		bm_ctl   = '0;
		bm_addr  = baddr_q;
		unique case (state_q)
			S_CLR: begin
				bm_ctl.we = 1'b1;
				bm_addr   = clr_q;
			end
			S_SPR: begin
				emit_v          = 1'b1;
				emit_res.status = (cmd_q == CMD_PUSH) ? ST_FULL : ST_LIMIT;
			end
			S_DIV: begin
				if (div_done) begin
					emit_v             = 1'b1;
					emit_res.status    = ST_OK;
					emit_res.msg_seq   = msgc_q;
					emit_res.seg_seq   = alloc_q;
					emit_res.seg_count = cnt_v;
					emit_res.out_id    = id_q;
					tbl_we             = 1'b1;
					tbl_wa             = cnt_q[IW-1:0];
					tbl_wd             = '{id: id_q, left: bytes_q, rd: rd_q,
						msg: msgc_q, start: alloc_q, count: cnt_v};
				end
			end
			S_NSCN: begin
				if (idx_q == cnt_q) begin
					emit_v          = 1'b1;
					emit_res.status = ST_EMPTY;
				end else if (e.left != 32'd0) begin
					emit_v               = 1'b1;
					emit_res.status      = ST_OK;
					emit_res.msg_seq     = e.msg;
					emit_res.seg_seq     = next_q;
					emit_res.seg_count   = e.count;
					emit_res.seg_len     = len;
					emit_res.payload_len = e.rd ? 13'd0 : len;
					emit_res.carrier_len = e.rd ? 13'd1 : len;
					emit_res.out_id      = e.id;
					tbl_we               = 1'b1;
					tbl_wd.left          = e.left - {19'd0, len};
				end
			end
			S_MARK: begin
				if (d_ack >= inflight) begin
					emit_v          = 1'b1;
					emit_res.status = d_ack[31] ? ST_STALE : ST_FUTURE;
				end else if (d_ack >= 32'(ACK_WINDOW)) begin
					emit_v          = 1'b1;
					emit_res.status = ST_WINDOW;
				end else begin
					bm_ctl.we   = 1'b1;
					bm_ctl.wbit = 1'b1;
					bm_addr     = mark_addr;
				end
			end
			S_RD: begin
				bm_ctl.re = (32'(k_q) < inflight) && (k_q < KW'(ACK_WINDOW));
			end
			S_CHK: begin
				bm_ctl.we = bm_rbit;
			end
			S_CMPL: begin
				if (idx_q != cnt_q) begin
					if (done_e && (ncmp_q < NW'(MAX_RESULTS))) begin
						emit_v             = 1'b1;
						emit_res.status    = ST_COMPLETE;
						emit_res.msg_seq   = e.msg;
						emit_res.seg_seq   = e.start;
						emit_res.seg_count = e.count;
						emit_res.out_id    = e.id;
					end else if (j_q != idx_q) begin
						tbl_we = 1'b1;
						tbl_wa = j_q[IW-1:0];
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (tbl_we) tbl_q[tbl_wa] <= tbl_wd;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			clr_q    <= '0;
			oldest_q <= '0;
			next_q   <= '0;
			msgc_q   <= '0;
			alloc_q  <= '0;
			ptr_q    <= '0;
			cnt_q    <= '0;
			hold_v_q <= 1'b0;
			strobe_q <= 1'b0;
			idx_q    <= '0;
			j_q      <= '0;
			k_q      <= '0;
			ncmp_q   <= '0;
			baddr_q  <= '0;
		end else begin
			strobe_q <= (emit_v && hold_v_q) || (state_q == S_FIN);
			if (emit_v) hold_v_q <= 1'b1;
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(ACK_WINDOW - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) begin
						idx_q <= '0;
						unique case (cmd)
							CMD_PUSH: state_q <= div_start ? S_DIV : S_SPR;
							CMD_NEXT: state_q <= (inflight >= {20'd0, limit_q}) ?
								S_SPR : S_NSCN;
							CMD_ACK:  state_q <= S_MARK;
							default:  state_q <= S_IDLE;
						endcase
					end
				end
				S_SPR: state_q <= S_FIN;
				S_DIV: begin
					if (div_done) begin
						cnt_q   <= cnt_q + 1'b1;
						msgc_q  <= msgc_q + 32'd1;
						alloc_q <= alloc_q + cnt_v;
						state_q <= S_FIN;
					end
				end
				S_NSCN: begin
					if (idx_q == cnt_q) state_q <= S_FIN;
					else if (e.left != 32'd0) begin
						next_q  <= next_q + 32'd1;
						state_q <= S_FIN;
					end else idx_q <= idx_q + 1'b1;
				end
				S_MARK: begin
					k_q     <= '0;
					baddr_q <= ptr_q;
					if (d_ack >= inflight || d_ack >= 32'(ACK_WINDOW)) state_q <= S_FIN;
					else state_q <= S_RD;
				end
				S_RD: state_q <= bm_ctl.re ? S_CHK : S_ADV;
				S_CHK: begin
					if (bm_rbit) begin
						k_q     <= k_q + 1'b1;
						baddr_q <= baddr_nx;
						state_q <= S_RD;
					end else state_q <= S_ADV;
				end
				S_ADV: begin
					idx_q  <= '0;
					j_q    <= '0;
					ncmp_q <= '0;
					if (k_q == '0) state_q <= S_FIN;
					else begin
						oldest_q <= oldest_q + 32'(k_q);
						ptr_q    <= baddr_q;
						state_q  <= S_CMPL;
					end
				end
				S_CMPL: begin
					if (idx_q == cnt_q) begin
						cnt_q   <= j_q;
						state_q <= S_FIN;
					end else begin
						idx_q <= idx_q + 1'b1;
						if (done_e && (ncmp_q < NW'(MAX_RESULTS))) ncmp_q <= ncmp_q + 1'b1;
						else j_q <= j_q + 1'b1;
					end
				end
				S_FIN: begin
					hold_v_q <= 1'b0;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// command capture, held word and output word
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= cmd;
			id_q    <= request_id;
			bytes_q <= request_bytes;
			rd_q    <= is_read;
			ack_q   <= ack_seq;
		end
		if (emit_v) hold_q <= emit_res;
		if (state_q == S_FIN) begin
			out_q  <= hold_v_q ? hold_q : '0;
			last_q <= 1'b1;
		end else if (emit_v && hold_v_q) begin
			out_q  <= hold_q;
			last_q <= 1'b0;
		end
	end

	ssaw_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (request_bytes),
		.divisor  (ss),
		.done     (div_done),
		.quotient (div_q),
		.rem_nz   (div_rem_nz)
	);

	ssaw_bitmap #(.DEPTH(ACK_WINDOW), .AW(AW)) u_bitmap (
		.clk  (clk),
		.ctl  (bm_ctl),
		.addr (bm_addr),
		.rbit (bm_rbit)
	);

	assign strobe      = strobe_q;
	assign status      = out_q.status;
	assign msg_seq     = out_q.msg_seq;
	assign seg_seq     = out_q.seg_seq;
	assign seg_count   = out_q.seg_count;
	assign seg_len     = out_q.seg_len;
	assign payload_len = out_q.payload_len;
	assign carrier_len = out_q.carrier_len;
	assign out_id      = out_q.out_id;
	assign last        = last_q;

	// a result that is not the final one leaves the block busy
	a_more_follows: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && !last_q |-> busy) else $error("non-final word with block idle");

	// the final word goes out as the block returns to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && last_q |-> !busy) else $error("final word with block busy");

	// queue fill never exceeds its depth
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(QUEUE_DEPTH)) else $error("queue overfilled");

	// completions per ack stay within the result limit
	a_ncmp: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CMPL |-> ncmp_q <= NW'(MAX_RESULTS)) else $error("too many completions");

endmodule

// File: src/ssaw_div.sv
module ssaw_div import ssaw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [12:0] divisor,
	output logic        done,
	output logic [31:0] quotient,
	output logic        rem_nz
);

	logic [12:0] rem_q;
	logic [31:0] quo_q;
	logic [4:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [13:0] trial;
	logic [13:0] diff;
	logic        ge;

	// one quotient bit a cycle
	always_comb begin
		trial = {rem_q, quo_q[31]};
		ge    = trial >= {1'b0, divisor};
		diff  = trial - {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == 5'd31);
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) run_q <= 1'b0;
			end
		end
	end

	// remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (run_q) begin
			rem_q <= ge ? diff[12:0] : trial[12:0];
			quo_q <= {quo_q[30:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
	assign rem_nz   = (rem_q != 13'd0);

endmodule

// File: src/ssaw_bitmap.sv
module ssaw_bitmap import ssaw_pkg::*; #(
	parameter int DEPTH = ACK_WINDOW_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  bm_ctl_t       ctl,
	input  logic [AW-1:0] addr,
	output logic          rbit
);

	logic mem_q [DEPTH];
	logic rbit_q;

	// single port bit store, registered read
	always_ff @(posedge clk) begin
		if (ctl.we) mem_q[addr] <= ctl.wbit;
		if (ctl.re) rbit_q <= mem_q[addr];
	end

	assign rbit = rbit_q;

endmodule

// File: sim/segment_sequencer_ack_window_tb.sv
`timescale 1ns / 1ps

module segment_sequencer_ack_window_tb;
	import ssaw_pkg::*;

	localparam int QUIET_LIMIT = 60000;
	localparam int DRAIN       = 80;

	// command code with no meaning, ignored by the block
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  cmd;
	logic [15:0] request_id;
	logic [31:0] request_bytes;
	logic        is_read;
	logic [31:0] ack_seq;
	logic        strobe;
	logic [2:0]  status;
	logic [31:0] msg_seq;
	logic [31:0] seg_seq;
	logic [31:0] seg_count;
	logic [12:0] seg_len;
	logic [12:0] payload_len;
	logic [12:0] carrier_len;
	logic [15:0] out_id;
	logic        last;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	segment_sequencer_ack_window dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// sequencer state as predicted
	logic [12:0]      seg_reg;
	logic [11:0]      limit_reg;
	logic [31:0]      oldest;
	logic [31:0]      send_seq;
	logic [31:0]      msg_ctr;
	logic [31:0]      alloc_ctr;
	logic [2047:0]    acked;
	req_entry_t       reqs [QUEUE_DEPTH_DEF];
	int               req_n;

	// results still to come
	result_t          pending_res [$];
	bit               pending_last [$];
	int               mismatches;
	int               quiet;
	int               burst_left;

	function automatic logic [31:0] seg_size();
		if (seg_reg == 13'd0) return 32'd1;
		if (seg_reg > 13'd4096) return 32'd4096;
		return {19'd0, seg_reg};
	endfunction

	function automatic void add_result(logic [2:0] st, logic [31:0] m, logic [31:0] s,
		logic [31:0] c, logic [12:0] ln, logic [12:0] pl, logic [12:0] cl, logic [15:0] id);
		result_t r;
		r = '{st, m, s, c, ln, pl, cl, id};
		pending_res = {pending_res, r};
		pending_last = {pending_last, 1'b0};
	endfunction

	// work out the results of one accepted command word
	function automatic void predict_word(logic [1:0] c, logic [15:0] id, logic [31:0] nbytes,
		logic rd, logic [31:0] aseq);
		logic [31:0] inflight, d, cnt, ln, past;
		logic [63:0] ss;
		int i, k, j, n;
		inflight = send_seq - oldest;
		n = pending_res.size();
		case (c)
			CMD_PUSH: begin
				if (req_n >= QUEUE_DEPTH_DEF) begin
					add_result(ST_FULL, 0, 0, 0, 0, 0, 0, 0);
				end else begin
					ss = {32'd0, seg_size()};
					cnt = 32'(({32'd0, nbytes} + ss - 64'd1) / ss);
					reqs[req_n] = '{id, nbytes, rd, msg_ctr, alloc_ctr, cnt};
					req_n++;
					add_result(ST_OK, msg_ctr, alloc_ctr, cnt, 0, 0, 0, id);
					msg_ctr = msg_ctr + 1;
					alloc_ctr = alloc_ctr + cnt;
				end
			end
			CMD_NEXT: begin
				if (inflight >= {20'd0, limit_reg}) begin
					add_result(ST_LIMIT, 0, 0, 0, 0, 0, 0, 0);
				end else begin
					for (i = 0; i < req_n; i++)
						if (reqs[i].left != 0) break;
					if (i >= req_n) begin
						add_result(ST_EMPTY, 0, 0, 0, 0, 0, 0, 0);
					end else begin
						ln = reqs[i].left;
						if (ln > seg_size()) ln = seg_size();
						add_result(ST_OK, reqs[i].msg, send_seq, reqs[i].count, ln[12:0],
							reqs[i].rd ? 13'd0 : ln[12:0], reqs[i].rd ? 13'd1 : ln[12:0],
							reqs[i].id);
						reqs[i].left = reqs[i].left - ln;
						send_seq = send_seq + 1;
					end
				end
			end
			CMD_ACK: begin
				d = aseq - oldest;
				if (d >= inflight) begin
					add_result(d[31] ? ST_STALE : ST_FUTURE, 0, 0, 0, 0, 0, 0, 0);
				end else if (d >= 32'd2048) begin
					add_result(ST_WINDOW, 0, 0, 0, 0, 0, 0, 0);
				end else begin
					acked[d[10:0]] = 1'b1;
					k = 0;
					while (k < inflight && k < 2048 && acked[k]) k++;
					if (k > 0) begin
						acked = acked >> k;
						oldest = oldest + k;
						j = 0;
						for (i = 0; i < req_n; i++) begin
							past = oldest - reqs[i].start;
							if (!past[31] && past >= reqs[i].count
									&& pending_res.size() - n < MAX_RESULTS) begin
								add_result(ST_COMPLETE, reqs[i].msg, reqs[i].start,
									reqs[i].count, 0, 0, 0, reqs[i].id);
							end else begin
								reqs[j] = reqs[i];
								j++;
							end
						end
						req_n = j;
					end
					if (pending_res.size() == n) add_result(ST_OK, 0, 0, 0, 0, 0, 0, 0);
				end
			end
			default: ;
		endcase
		if (pending_res.size() > n) pending_last[pending_last.size() - 1] = 1'b1;
	endfunction

	function automatic void report(string msg);
		mismatches++;
		if (mismatches <= 10) $display("mismatch: %s", msg);
	endfunction

	// compare each result word with the oldest prediction
	always @(posedge clk) begin
		result_t got, want;
		bit want_last;
		if (arst_n && strobe) begin
			got = '{status, msg_seq, seg_seq, seg_count, seg_len, payload_len, carrier_len,
				out_id};
			if (pending_res.size() == 0) begin
				report($sformatf("unexpected result %h last %b", got, last));
			end else begin
				want = pending_res.pop_front();
				want_last = pending_last.pop_front();
				if (got !== want || last !== want_last)
					report($sformatf("expected %h last %b, got %h last %b",
						want, want_last, got, last));
			end
		end
	end

	// watchdog on cycles with no word moving
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || strobe) quiet = 0;
			else quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("** segment_sequencer_ack_window: FAILED **");
				$finish;
			end
		end
	end

	// bursts with random gaps in between
	task automatic pace();
		burst_left--;
		if (burst_left <= 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30)
				: $urandom_range(1, 6);
		end
	endtask

	task automatic send_word(logic [1:0] c, logic [15:0] id, logic [31:0] nbytes, logic rd,
		logic [31:0] aseq);
		start <= 1'b1;
		cmd <= c;
		request_id <= id;
		request_bytes <= nbytes;
		is_read <= rd;
		ack_seq <= aseq;
		do @(posedge clk); while (busy);
		predict_word(c, id, nbytes, rd, aseq);
		pace();
	endtask

	task automatic push(logic [31:0] nbytes, logic rd);
		send_word(CMD_PUSH, 16'($urandom), nbytes, rd, 32'($urandom));
	endtask

	task automatic next_seg();
		send_word(CMD_NEXT, 16'($urandom), 32'($urandom), 1'($urandom), 32'($urandom));
	endtask

	task automatic ack(logic [31:0] s);
		send_word(CMD_ACK, 16'($urandom), 32'($urandom), 1'($urandom), s);
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		do @(posedge clk); while (pending_res.size() != 0 || busy);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] v);
		logic [31:0] mask;
		wait_idle();
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (idx == REG_SEG_BYTES) seg_reg = v[12:0];
		else limit_reg = v[11:0];
		// read it back
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		mask = (idx == REG_SEG_BYTES) ? 32'h1FFF : 32'hFFF;
		if ((prdata & mask) !== (v & mask))
			report($sformatf("register %0d read %h, wrote %h", idx, prdata, v));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// edge sizes, stale, future and empty refusals and an out-of-order ack run
	task automatic test_basic();
		push(32'd0, 1'b0);
		push(32'd1, 1'b1);
		push(32'd4097, 1'b0);
		send_word(CMD_PUSH, 16'hFFFF, 32'd7, 1'b1, 32'hFFFF_FFFF);
		send_word(CMD_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
		repeat (5) next_seg();
		next_seg();
		ack(32'hFFFF_FFFF);
		ack(32'd5);
		ack(32'd2);
		ack(32'd1);
		ack(32'd1);
		ack(32'd0);
		ack(32'd3);
	endtask

	// fill the queue, refuse one more, then retire all at once
	task automatic test_full();
		logic [31:0] base;
		int i;
		for (i = req_n; i < QUEUE_DEPTH_DEF; i++) push($urandom_range(1, 4096), 1'($urandom));
		push(32'd10, 1'b0);
		base = send_seq;
		for (i = 0; i < QUEUE_DEPTH_DEF; i++) next_seg();
		for (i = QUEUE_DEPTH_DEF - 1; i >= 0; i--) ack(base + i);
	endtask

	// register extremes: zero limit, limit one, clamped segment sizes
	task automatic test_limits();
		write_reg(REG_LIMIT, 32'd0);
		push(32'd10, 1'b0);
		next_seg();
		write_reg(REG_LIMIT, 32'd1);
		next_seg();
		next_seg();
		ack(oldest);
		write_reg(REG_SEG_BYTES, 32'd0);
		push(32'd3, 1'b0);
		repeat (3) begin
			next_seg();
			ack(oldest);
		end
		write_reg(REG_SEG_BYTES, 32'h1FFF);
		push(32'd5000, 1'b1);
		repeat (2) begin
			next_seg();
			ack(oldest);
		end
		write_reg(REG_LIMIT, 32'd2048);
		write_reg(REG_SEG_BYTES, 32'd4096);
	endtask

	// mostly well-formed traffic with random content, some noise
	task automatic test_random(logic [31:0] seg, logic [31:0] lim, int words);
		int done_words, pick;
		logic [31:0] inflight;
		write_reg(REG_SEG_BYTES, seg);
		write_reg(REG_LIMIT, lim);
		done_words = 0;
		while (done_words < words) begin
			pick = $urandom_range(0, 99);
			inflight = send_seq - oldest;
			if (pick < 5) begin
				send_word(CMD_UNUSED, 16'($urandom), 32'($urandom), 1'($urandom),
					32'($urandom));
				done_words--;
			end else if (pick < 35 && req_n < QUEUE_DEPTH_DEF - 1) begin
				push($urandom_range(0, 3 * seg_size()), 1'($urandom));
			end else if (pick < 65) begin
				next_seg();
			end else if (inflight != 0 && pick < 92) begin
				ack(oldest + $urandom_range(0, inflight - 1));
			end else begin
				ack(($urandom_range(0, 1) == 0) ? 32'($urandom) : oldest + 1);
			end
			done_words++;
		end
	endtask

	// largest sizes: byte counts at full width, allocation counter wraps
	task automatic test_huge();
		write_reg(REG_SEG_BYTES, 32'd1);
		push(32'hFFFF_FFFF, 1'b1);
		write_reg(REG_SEG_BYTES, 32'd4096);
		push(32'($urandom), 1'b0);
		push(32'h8000_0000, 1'b1);
		repeat (4) next_seg();
		ack(oldest);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = CMD_PUSH;
		request_id = '0;
		request_bytes = '0;
		is_read = 1'b0;
		ack_seq = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		seg_reg = SEG_BYTES_RST;
		limit_reg = LIMIT_RST;
		oldest = '0;
		send_seq = '0;
		msg_ctr = '0;
		alloc_ctr = '0;
		acked = '0;
		req_n = 0;
		mismatches = 0;
		quiet = 0;
		burst_left = 4;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		test_basic();
		test_full();
		// hold off until the sequencer has gone quiet
		wait_idle();
		test_limits();
		test_random(32'd64, 32'd2, 10);
		test_random(32'd1000, 32'd8, 10);
		test_random(32'd4096, 32'd2048, 10);
		test_huge();

		start <= 1'b0;
		do @(posedge clk); while (pending_res.size() != 0);
		repeat (DRAIN) @(posedge clk);
		if (mismatches == 0) begin
			$display("** segment_sequencer_ack_window: PASSED **");
		end else begin
			$display("** segment_sequencer_ack_window: FAILED **");
		end
		$finish;
	end

endmodule
